### hdl/pe_pkg.sv
// Shared types and constants of the Prewitt edge detector.
`timescale 1ns / 1ps
package pe_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam int unsigned CFG_DW = 11;
  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [10:0] HEIGHT_RST = 11'd480;
  localparam logic [7:0]  THRESH_RST = 8'd20;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_SQ,
    ST_SQRT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic       edge_res;
    logic [7:0] magnitude;
    logic [7:0] grad_x;
    logic [7:0] grad_y;
    logic [7:0] grad_diag;
    logic       last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic calc;
    logic sq;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic emit;
    logic sqrt_last;
    logic out_free;
  } status_t;

endpackage

### hdl/prewitt_edge_detector.sv
// Top level of the streaming 3x3 Prewitt edge detector.
`timescale 1ns / 1ps
// Usage notes
// - Input channel (in_valid_i/in_ready_o/in_data_i): one transfer per pixel in
//   raster order (mode 0), then width+1 flush ticks (mode 1) drain the frame.
//   Pixels after the last one and before the drain ends are dropped, as are
//   flush ticks while the frame is still coming in.
// - Output channel (out_valid_o/out_ready_i/out_data_o): one transfer per
//   result, trailing the input by one row plus one pixel.
// - Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i at once.
//   Width or height writes restart the frame. Write only while idle.
// - Timing: one item at a time. An item producing a result passes from accept
//   to result load through store read, window update, squaring and nine root
//   steps; the next item is taken the cycle after. An item without a result
//   frees the input after the store read and window update, a dropped one
//   after the store read. The nine-step root unit sets rate while the receiver keeps up.
// - A finished result sits in the output register; the next item is accepted
//   and worked on meanwhile, and only the result load waits for the receiver.
// - Reset: config returns to 640 x 480, threshold 20, frame at (0, 0). The
//   line stores need no clearing: every entry is written before it is read.
module prewitt_edge_detector import pe_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  pe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pe_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // one item in flight: no transfer in the cycle after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // an edge needs a non-zero magnitude
  a_edge_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.edge_res |-> out_data_o.magnitude != 8'd0)
    else $error("edge flagged with zero magnitude");

  // flat gradients give zero magnitude
  a_flat_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.grad_x == 8'd0 && out_data_o.grad_y == 8'd0
    |-> out_data_o.magnitude == 8'd0)
    else $error("magnitude non-zero with zero gradients");

endmodule

### hdl/pe_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module pe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pe_datapath.sv
// Datapath: config, position counters, line stores, window, gradients, root unit.
`timescale 1ns / 1ps
module pe_datapath import pe_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  in_item_t          in_data_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output out_item_t         out_data_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = AW + 1;
  localparam int unsigned RW = $clog2(MAX_HEIGHT) + 2;

  function automatic logic signed [11:0] ext(input logic [7:0] v);
    ext = $signed({4'b0, v});
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [11:0] s);
    if (s <= 12'sd0) clamp8 = 8'd0;
    else if (s >= 12'sd255) clamp8 = 8'd255;
    else clamp8 = s[7:0];
  endfunction

  logic [10:0]   width_q, height_q;
  logic [7:0]    thr_q;
  logic [AW-1:0] c_q;
  logic [RW-1:0] r_q;
  logic          mode_q;
  logic [7:0]    pix_q;
  logic [7:0]    win_q [9];
  logic [7:0]    win_d [9];
  logic [7:0]    nb [9];
  logic [WW-1:0] dim_w;
  logic [RW-1:0] dim_h;
  logic [AW-1:0] c_eff;
  logic [WW-1:0] c_nxt;
  logic          c_zero, last;
  logic [7:0]    up_rd, mid_rd, top, mid, bot;
  logic signed [11:0] sx, sy, sd;
  logic [7:0]    gx_q, gy_q, gd_q;
  logic          last_q;
  logic [17:0]   rad_q;
  logic [9:0]    rem_q;
  logic [8:0]    root_q;
  logic [3:0]    cnt_q;
  logic [11:0]   rem_sh, trial;
  logic [7:0]    mag;
  logic          out_valid_q;
  out_item_t     out_q;

  // clamped geometry
  always_comb begin
    if (width_q < 11'd3) dim_w = WW'(3);
    else if (32'(width_q) > MAX_WIDTH) dim_w = WW'(MAX_WIDTH);
    else dim_w = WW'(width_q);
    if (height_q < 11'd3) dim_h = RW'(3);
    else if (32'(height_q) > MAX_HEIGHT) dim_h = RW'(MAX_HEIGHT);
    else dim_h = RW'(height_q);
  end

  assign c_eff  = ({1'b0, c_q} >= dim_w) ? '0 : c_q;
  assign c_zero = (c_eff == '0);
  assign last   = (r_q == dim_h + RW'(1)) && c_zero;
  assign c_nxt  = {1'b0, c_eff} + WW'(1);

  pe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (cmd_i.calc),
    .waddr_i (c_eff),
    .wdata_i (mid),
    .raddr_i (c_eff),
    .rdata_o (up_rd)
  );

  pe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram_middle (
    .clk_i   (clk_i),
    .we_i    (cmd_i.calc),
    .waddr_i (c_eff),
    .wdata_i (bot),
    .raddr_i (c_eff),
    .rdata_o (mid_rd)
  );

  assign top = (r_q >= RW'(2) && r_q <= dim_h + RW'(1)) ? up_rd : 8'd0;
  assign mid = (r_q >= RW'(1) && r_q <= dim_h) ? mid_rd : 8'd0;
  assign bot = (r_q < dim_h) ? pix_q : 8'd0;

  // shifted window; right column is the new column, or zero past the row end
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nb[k*3]     = win_q[k*3+1];
      nb[k*3+1]   = win_q[k*3+2];
      nb[k*3+2]   = 8'd0;
      win_d[k*3]  = c_zero ? 8'd0 : win_q[k*3+1];
      win_d[k*3+1] = c_zero ? 8'd0 : win_q[k*3+2];
    end
    if (!c_zero) begin
      nb[2] = top;
      nb[5] = mid;
      nb[8] = bot;
    end
    win_d[2] = top;
    win_d[5] = mid;
    win_d[8] = bot;
  end

  assign sx = (ext(nb[2]) + ext(nb[5]) + ext(nb[8])) - (ext(nb[0]) + ext(nb[3]) + ext(nb[6]));
  assign sy = (ext(nb[6]) + ext(nb[7]) + ext(nb[8])) - (ext(nb[0]) + ext(nb[1]) + ext(nb[2]));
  assign sd = ext(nb[5]) + ext(nb[7]) + (ext(nb[8]) <<< 1)
            - (ext(nb[0]) <<< 1) - ext(nb[1]) - ext(nb[3]);

  assign status_o.drop = (!mode_q && r_q >= dim_h) || (mode_q && r_q < dim_h);
  assign status_o.emit = c_zero ? (r_q >= RW'(2)) : (r_q >= RW'(1));
  assign status_o.sqrt_last = (cnt_q == 4'd8);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // config and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      thr_q    <= THRESH_RST;
      c_q      <= '0;
      r_q      <= '0;
      for (int i = 0; i < 9; i++) win_q[i] <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH: begin
          width_q <= cfg_data_i;
          c_q     <= '0;
          r_q     <= '0;
        end
        CFG_HEIGHT: begin
          height_q <= cfg_data_i;
          c_q      <= '0;
          r_q      <= '0;
        end
        CFG_THRESH: thr_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end else if (cmd_i.calc) begin
      win_q <= win_d;
      if (last) begin
        c_q <= '0;
        r_q <= '0;
      end else if (c_nxt >= dim_w) begin
        c_q <= '0;
        r_q <= r_q + RW'(1);
      end else begin
        c_q <= c_nxt[AW-1:0];
      end
    end
  end

  // integer square root, two radicand bits per step
  assign rem_sh = {rem_q, rad_q[17:16]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign mag    = root_q[8] ? 8'd255 : root_q[7:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q <= in_data_i.mode;
      pix_q  <= in_data_i.pixel;
    end
    if (cmd_i.calc) begin
      gx_q   <= clamp8(sx);
      gy_q   <= clamp8(sy);
      gd_q   <= clamp8(sd);
      last_q <= last;
    end
    if (cmd_i.sq) begin
      rad_q  <= 18'(16'(gx_q * gx_q)) + 18'(16'(gy_q * gy_q));
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.step) begin
      rad_q <= {rad_q[15:0], 2'b00};
      cnt_q <= cnt_q + 4'd1;
      if (rem_sh >= trial) begin
        rem_q  <= 10'(rem_sh - trial);
        root_q <= {root_q[7:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[9:0];
        root_q <= {root_q[7:0], 1'b0};
      end
    end
    if (cmd_i.load_out) begin
      out_q.edge_res      <= (mag > thr_q);
      out_q.magnitude     <= mag;
      out_q.grad_x        <= gx_q;
      out_q.grad_y        <= gy_q;
      out_q.grad_diag     <= gd_q;
      out_q.last_of_frame <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/pe_ctrl.sv
// Controller state machine sequencing one input item through the datapath.
`timescale 1ns / 1ps
module pe_ctrl import pe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        // line store read issued here, data valid next cycle
        state_d = status_i.drop ? ST_IDLE : ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = status_i.emit ? ST_SQ : ST_IDLE;
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.step = 1'b1;
        if (status_i.sqrt_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
